// File: hdl/rfbcrc_pkg.sv
// Shared constants, types and the CRC byte update for the radio frame builder.
package rfbcrc_pkg;

    localparam int MAX_DATA_BYTES_DEF = 16;

    localparam logic [7:0]  START_BYTE = 8'hAA;
    localparam logic [7:0]  END_BYTE   = 8'h00;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // Bytes that one input beat can produce: start, header, data, CRC high, CRC low, end.
    localparam int GROUP_BYTES = 6;
    localparam int GROUP_CNT_W = $clog2(GROUP_BYTES + 1);

    typedef logic [7:0] byte_t;

    // One group of result bytes, in wire order from index 0.
    typedef struct packed {
        byte_t [GROUP_BYTES-1:0] bytes;
        logic [GROUP_CNT_W-1:0]  count;
        logic                    has_end;
    } group_t;

    // CRC-16-CCITT update over one byte, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_t b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // The start byte is fixed, so the CRC after it is a constant.
    localparam logic [15:0] CRC_AFTER_START = crc_byte(CRC_INIT, START_BYTE);

endpackage

// File: hdl/rfbcrc_out_shift.sv
// Output stage: holds the bytes of one input beat and sends them out one beat at a time.
module rfbcrc_out_shift
    import rfbcrc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   load,
    input  group_t grp,
    output logic   load_ok,
    output logic   frame_valid,
    input  logic   frame_ready,
    output byte_t  frame_byte,
    output logic   frame_end
);

    byte_t [GROUP_BYTES-1:0] bytes_reg;
    byte_t [GROUP_BYTES-1:0] bytes_next;
    logic [GROUP_CNT_W-1:0]  count_reg;
    logic [GROUP_CNT_W-1:0]  count_next;
    logic                    end_reg;
    logic                    end_next;
    logic                    pop;
    logic                    last_byte;

    assign last_byte   = (count_reg == GROUP_CNT_W'(1));
    assign frame_valid = (count_reg != '0);
    assign pop         = frame_valid && frame_ready;
    // A new group may come in as the last byte of the current one leaves.
    assign load_ok     = (count_reg == '0) || (last_byte && frame_ready);
    assign frame_byte  = bytes_reg[0];
    assign frame_end   = end_reg && last_byte;

    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        end_next   = end_reg;
        if (load)
        begin
            bytes_next = grp.bytes;
            count_next = grp.count;
            end_next   = grp.has_end;
        end
        else if (pop)
        begin
            for (int i = 0; i < GROUP_BYTES - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i+1];
            end
            bytes_next[GROUP_BYTES-1] = END_BYTE;
            count_next = count_reg - GROUP_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == '0) || (last_byte && pop))
        else $error("group loaded over bytes not yet sent");

    a_group_size: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (grp.count == GROUP_CNT_W'(1)) || (grp.count == GROUP_CNT_W'(3)) ||
                 (grp.count == GROUP_CNT_W'(4)) || (grp.count == GROUP_CNT_W'(6)))
        else $error("group size is not a possible frame piece");

    a_pop_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !load) |=> count_reg == $past(count_reg) - GROUP_CNT_W'(1))
        else $error("byte count did not step down on a sent beat");

    a_end_closes_group: assert property (@(posedge clk) disable iff (!rst_n)
        (load && grp.has_end) |-> grp.bytes[grp.count - GROUP_CNT_W'(1)] == END_BYTE)
        else $error("group marked as frame end does not close with the end byte");

endmodule

// File: hdl/radio_frame_builder_crc16_unit.sv
// Top level of the radio frame builder with CRC-16-CCITT.
//
// Input channel (data_valid/data_ready): one payload byte per beat. On the
// first beat of a frame slave_id, ack_flag and data_count are sampled too; a
// count of 0 is taken as 1 and a count above MAX_DATA_BYTES as MAX_DATA_BYTES.
// Output channel (frame_valid/frame_ready): one frame byte per beat. The first
// beat of a frame yields start byte, header and data; middle beats yield the
// data byte; the counted last beat adds CRC high, CRC low and the end byte,
// which carries frame_end.
// The first result byte of an input beat appears on the output in the cycle
// after it is accepted. An input beat is taken once the output is empty or as
// the last byte of the previous one is sent, so the input pace is set by the
// number of bytes each beat expands to on the single byte-wide output port;
// middle bytes of a frame flow at one per cycle when neither side stalls.
// Reset clears the output stage and returns the block to the start of a frame
// with the CRC at 0xFFFF. When the receiver stalls, the current byte holds on
// the output and data_ready drops once the pending bytes cannot drain.
module radio_frame_builder_crc16_unit
    import rfbcrc_pkg::*;
#(
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_ready,
    input  logic [7:0] data_byte,
    input  logic [2:0] slave_id,
    input  logic       ack_flag,
    input  logic [4:0] data_count,
    output logic       frame_valid,
    input  logic       frame_ready,
    output logic [7:0] frame_byte,
    output logic       frame_end
);

    localparam logic [4:0] MAX_CNT = 5'(MAX_DATA_BYTES);

    logic        inside_frame_reg;
    logic        inside_frame_next;
    logic [4:0]  bytes_left_reg;
    logic [4:0]  bytes_left_next;
    logic [15:0] crc_accum_reg;
    logic [15:0] crc_accum_next;

    logic        accept;
    logic [4:0]  cnt_clamped;
    logic [4:0]  cnt_m1;
    byte_t       header;
    logic [15:0] crc_base;
    logic [15:0] crc_after;
    logic        last;
    group_t      grp;

    assign accept = data_valid && data_ready;

    always_comb
    begin
        if (data_count == 5'd0)
        begin
            cnt_clamped = 5'd1;
        end
        else if (data_count > MAX_CNT)
        begin
            cnt_clamped = MAX_CNT;
        end
        else
        begin
            cnt_clamped = data_count;
        end
        cnt_m1 = cnt_clamped - 5'd1;
        header = {slave_id, ack_flag, cnt_m1[3:0]};

        // On the first byte the header joins the CRC after the constant start byte.
        crc_base  = inside_frame_reg ? crc_accum_reg : crc_byte(CRC_AFTER_START, header);
        crc_after = crc_byte(crc_base, data_byte);

        bytes_left_next = inside_frame_reg ? (bytes_left_reg - 5'd1) : cnt_m1;
        last            = (bytes_left_next == 5'd0);

        grp.bytes = '0;
        if (!inside_frame_reg)
        begin
            grp.bytes[0] = START_BYTE;
            grp.bytes[1] = header;
            grp.bytes[2] = data_byte;
            if (last)
            begin
                grp.bytes[3] = crc_after[15:8];
                grp.bytes[4] = crc_after[7:0];
                grp.bytes[5] = END_BYTE;
                grp.count    = GROUP_CNT_W'(6);
            end
            else
            begin
                grp.count = GROUP_CNT_W'(3);
            end
        end
        else
        begin
            grp.bytes[0] = data_byte;
            if (last)
            begin
                grp.bytes[1] = crc_after[15:8];
                grp.bytes[2] = crc_after[7:0];
                grp.bytes[3] = END_BYTE;
                grp.count    = GROUP_CNT_W'(4);
            end
            else
            begin
                grp.count = GROUP_CNT_W'(1);
            end
        end
        grp.has_end = last;

        inside_frame_next = !last;
        crc_accum_next    = last ? CRC_INIT : crc_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
            bytes_left_reg   <= 5'd0;
            crc_accum_reg    <= CRC_INIT;
        end
        else if (accept)
        begin
            inside_frame_reg <= inside_frame_next;
            bytes_left_reg   <= bytes_left_next;
            crc_accum_reg    <= crc_accum_next;
        end
    end

    rfbcrc_out_shift u_out_shift (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .grp         (grp),
        .load_ok     (data_ready),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end)
    );

    a_idle_crc_init: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_frame_reg |-> (crc_accum_reg == CRC_INIT) && (bytes_left_reg == 5'd0))
        else $error("CRC or byte count not cleared between frames");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        inside_frame_reg |-> (bytes_left_reg != 5'd0) && (bytes_left_reg < MAX_CNT))
        else $error("bytes left out of range inside a frame");

    a_end_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && grp.has_end) |=> !inside_frame_reg)
        else $error("frame end did not return to the start of a frame");

endmodule

// File: tb/sv/tb_radio_frame_builder_crc16_unit.sv
// Self-checking testbench for the radio frame builder with CRC-16-CCITT.
module tb_radio_frame_builder_crc16_unit;
    import rfbcrc_pkg::*;

    localparam int MAX_BYTES     = MAX_DATA_BYTES_DEF;
    localparam int BEATS_WANTED  = 430;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES   = 20;

    typedef struct {
        logic [7:0] data;
        logic [2:0] sid;
        logic       ack;
        logic [4:0] cnt;
        bit         drain_first;
    } input_beat_t;

    typedef struct {
        logic [7:0] wire_byte;
        logic       last;
    } frame_out_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       data_valid = 1'b0;
    logic       data_ready;
    logic [7:0] data_byte = 8'h00;
    logic [2:0] slave_id = 3'd0;
    logic       ack_flag = 1'b0;
    logic [4:0] data_count = 5'd0;
    logic       frame_valid;
    logic       frame_ready = 1'b0;
    logic [7:0] frame_byte;
    logic       frame_end;

    input_beat_t beat_q[$];
    frame_out_t  expected_bytes[$];

    int beats_planned = 0;
    int beats_taken = 0;
    int mismatches = 0;
    int cycle_count = 0;
    bit hold_rx = 1'b0;

    // Predictor state.
    bit          in_frame = 1'b0;
    logic [4:0]  bytes_remaining = 5'd0;
    logic [15:0] frame_crc = CRC_INIT;

    wire steady = (beats_taken >= 200) && (beats_taken < 300);

    radio_frame_builder_crc16_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_ready  (data_ready),
        .data_byte   (data_byte),
        .slave_id    (slave_id),
        .ack_flag    (ack_flag),
        .data_count  (data_count),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_byte  (frame_byte),
        .frame_end   (frame_end)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Bit-serial form of the CCITT update: feed each message bit into the top.
    function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] acc,
                                                     input logic [7:0] b);
        logic [15:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            if (r[15] ^ b[i])
            begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    task automatic push_wire_byte(input logic [7:0] b, input logic last);
        frame_out_t o;
        o.wire_byte = b;
        o.last = last;
        expected_bytes.push_back(o);
    endtask

    task automatic predict_frame_bytes(input logic [7:0] d, input logic [2:0] sid,
                                       input logic a, input logic [4:0] cnt);
        logic [4:0] n;
        logic [7:0] hdr;
        if (!in_frame)
        begin
            if (cnt == 5'd0)
            begin
                n = 5'd1;
            end
            else if (cnt > MAX_BYTES)
            begin
                n = 5'(MAX_BYTES);
            end
            else
            begin
                n = cnt;
            end
            hdr = {sid, a, 4'(n - 5'd1)};
            frame_crc = crc16_ccitt_step(CRC_INIT, START_BYTE);
            push_wire_byte(START_BYTE, 1'b0);
            frame_crc = crc16_ccitt_step(frame_crc, hdr);
            push_wire_byte(hdr, 1'b0);
            in_frame = 1'b1;
            bytes_remaining = n - 5'd1;
        end
        else
        begin
            bytes_remaining = bytes_remaining - 5'd1;
        end
        frame_crc = crc16_ccitt_step(frame_crc, d);
        push_wire_byte(d, 1'b0);
        if (bytes_remaining == 5'd0)
        begin
            push_wire_byte(frame_crc[15:8], 1'b0);
            push_wire_byte(frame_crc[7:0], 1'b0);
            push_wire_byte(END_BYTE, 1'b1);
            in_frame = 1'b0;
            frame_crc = CRC_INIT;
        end
    endtask

    task automatic plan_beat(input logic [7:0] d, input logic [2:0] sid, input logic a,
                             input logic [4:0] cnt, input bit drain);
        input_beat_t b;
        b.data = d;
        b.sid = sid;
        b.ack = a;
        b.cnt = cnt;
        b.drain_first = drain;
        beat_q.push_back(b);
        beats_planned++;
    endtask

    // One frame with random content; the header fields of later beats are noise.
    task automatic plan_random_frame(input bit drain);
        logic [4:0] cnt;
        int         n;
        int         r;
        r = $urandom_range(99);
        if (r < 3)
        begin
            cnt = 5'd0;
        end
        else if (r < 9)
        begin
            cnt = 5'($urandom_range(17, 31));
        end
        else
        begin
            cnt = 5'($urandom_range(1, MAX_BYTES));
        end
        n = (cnt == 0) ? 1 : (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
        plan_beat(8'($urandom), 3'($urandom), 1'($urandom), cnt, drain);
        for (int i = 1; i < n; i++)
        begin
            plan_beat(8'($urandom), 3'($urandom), 1'($urandom), 5'($urandom), 1'b0);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("MISMATCH %s: got %02h expected %02h at cycle %0d",
                 what, got, want, cycle_count);
    endtask

    // Stimulus and end of run.
    initial
    begin
        bit paused_late;
        paused_late = 1'b0;

        // Single-byte frames: all-zero fields, and a zero count taken as one.
        plan_beat(8'h00, 3'd0, 1'b0, 5'd1, 1'b0);
        plan_beat(8'hFF, 3'd7, 1'b1, 5'd0, 1'b0);
        // Two-byte frame whose second beat carries fields that must be ignored.
        plan_beat(8'h5A, 3'd5, 1'b0, 5'd2, 1'b0);
        plan_beat(8'hA5, 3'd2, 1'b1, 5'd0, 1'b0);
        plan_beat(8'h80, 3'd3, 1'b1, 5'd3, 1'b0);
        plan_beat(8'h01, 3'd7, 1'b0, 5'd31, 1'b0);
        plan_beat(8'h7F, 3'd0, 1'b1, 5'd16, 1'b0);
        // Count above the maximum saturates to a full frame.
        plan_beat(8'hFF, 3'd7, 1'b1, 5'd31, 1'b0);
        for (int i = 1; i < MAX_BYTES; i++)
        begin
            plan_beat((i % 2) ? 8'h00 : 8'hFF, 3'($urandom), 1'($urandom),
                      5'($urandom), 1'b0);
        end

        plan_random_frame(1'b1);
        while (beats_planned < BEATS_WANTED)
        begin
            if (!paused_late && beats_planned >= 320)
            begin
                plan_random_frame(1'b1);
                paused_late = 1'b1;
            end
            else
            begin
                plan_random_frame(1'b0);
            end
        end

        while (beat_q.size() != 0 || data_valid)
        begin
            @(posedge clk);
        end
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Input driver: takes the next planned beat when the slot is free.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_valid <= 1'b0;
        end
        else
        begin
            if (data_valid && data_ready)
            begin
                predict_frame_bytes(data_byte, slave_id, ack_flag, data_count);
                beats_taken <= beats_taken + 1;
            end
            if (!data_valid || data_ready)
            begin
                if (beat_q.size() != 0 && (steady || $urandom_range(99) >= 33) &&
                    !(beat_q[0].drain_first && expected_bytes.size() != 0))
                begin
                    data_valid <= 1'b1;
                    data_byte  <= beat_q[0].data;
                    slave_id   <= beat_q[0].sid;
                    ack_flag   <= beat_q[0].ack;
                    data_count <= beat_q[0].cnt;
                    beat_q.pop_front();
                end
                else
                begin
                    data_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering beats.
    initial
    begin
        while (beats_taken < 60)
        begin
            @(posedge clk);
        end
        hold_rx <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ready <= 1'b0;
        end
        else
        begin
            frame_ready <= !hold_rx && (steady || $urandom_range(99) >= 33);
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && frame_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected beat", frame_byte, 8'h00);
            end
            else
            begin
                if (frame_byte !== expected_bytes[0].wire_byte)
                begin
                    report_mismatch("frame_byte", frame_byte, expected_bytes[0].wire_byte);
                end
                if (frame_end !== expected_bytes[0].last)
                begin
                    report_mismatch("frame_end", 8'(frame_end), 8'(expected_bytes[0].last));
                end
                expected_bytes.pop_front();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
